// ===== sv/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants for the 3x3 box blur
// Pixel and window types, the neighbour-count and reciprocal tables.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int CH_W      = 8;   // one colour channel
	localparam int PIX_W     = 3 * CH_W;
	localparam int CSUM_W    = 10;  // sum of three channel values
	localparam int SUM_W     = 12;  // sum of nine channel values
	localparam int N_W       = 4;   // neighbour count, 1..9
	localparam int X_W       = 13;  // 2*sum + n
	localparam int RCP_W     = 18;  // reciprocal of 2*n
	localparam int RCP_SHIFT = 18;
	localparam int PROD_W    = X_W + RCP_W;

	// configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 13;
	localparam int FW_W      = 11;
	localparam int FH_W      = 13;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// item kinds on tuser
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pix_t;

	// one window column, top row to bottom row
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	// one line store word: the two rows above the incoming pixel
	typedef struct packed {
		pix_t older;
		pix_t prev;
	} lb_word_t;

	typedef struct packed {
		logic top_ok;
		logic bot_ok;
	} row_mask_t;

	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} win_mask_t;

	typedef struct packed {
		logic [CSUM_W-1:0] blue;
		logic [CSUM_W-1:0] green;
		logic [CSUM_W-1:0] red;
	} csum_t;

	typedef struct packed {
		logic [SUM_W-1:0] blue;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] red;
	} sum_t;

	// number of in-frame pixels in the window
	function automatic logic [N_W-1:0] nbr_count(input win_mask_t m);
		logic [1:0] rows;
		logic [1:0] cols;
		rows = 2'd1 + 2'(m.top_ok) + 2'(m.bot_ok);
		cols = 2'd1 + 2'(m.left_ok) + 2'(m.right_ok);
		return N_W'(rows) * N_W'(cols);
	endfunction

	// floor(2^18 / (2n)) + 1: exact floor division of any 13-bit x by 2n
	function automatic logic [RCP_W-1:0] recip(input logic [N_W-1:0] n);
		logic [RCP_W-1:0] m;
		case (n)
			4'd1:    m = 18'd131073;
			4'd2:    m = 18'd65537;
			4'd3:    m = 18'd43691;
			4'd4:    m = 18'd32769;
			4'd6:    m = 18'd21846;
			4'd9:    m = 18'd14564;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// ===== sv/bb3_cell.sv =====
// ----------------------------------------------------------------------------
// bb3_cell: one column of the 3x3 window
// Holds three pixels, takes its neighbour's column on a shift, and gives the
// per-channel sum of its in-frame rows.
// ----------------------------------------------------------------------------
module bb3_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  bb3_pkg::col_t      col_in,
	input  bb3_pkg::row_mask_t rows,
	output bb3_pkg::col_t      col_q,
	output bb3_pkg::csum_t     csum
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	always_comb begin
		csum.red   = bb3_pkg::CSUM_W'(rows.top_ok ? col_q.top.red : '0)
		           + bb3_pkg::CSUM_W'(col_q.mid.red)
		           + bb3_pkg::CSUM_W'(rows.bot_ok ? col_q.bot.red : '0);
		csum.green = bb3_pkg::CSUM_W'(rows.top_ok ? col_q.top.green : '0)
		           + bb3_pkg::CSUM_W'(col_q.mid.green)
		           + bb3_pkg::CSUM_W'(rows.bot_ok ? col_q.bot.green : '0);
		csum.blue  = bb3_pkg::CSUM_W'(rows.top_ok ? col_q.top.blue : '0)
		           + bb3_pkg::CSUM_W'(col_q.mid.blue)
		           + bb3_pkg::CSUM_W'(rows.bot_ok ? col_q.bot.blue : '0);
	end

endmodule

// ===== sv/bb3_line_buf.sv =====
// ----------------------------------------------------------------------------
// bb3_line_buf: two-row line store
// One word per column holds the two previous rows; registered read.
// ----------------------------------------------------------------------------
module bb3_line_buf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output bb3_pkg::lb_word_t rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  bb3_pkg::lb_word_t wr_data
);

	bb3_pkg::lb_word_t mem [DEPTH];

	// read gives the old word on a same-address write; caller forwards
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/bb3_norm.sv =====
// ----------------------------------------------------------------------------
// bb3_norm: rounded mean of one channel
// floor((2*sum + n) / (2n)) by reciprocal multiply, result registered.
// ----------------------------------------------------------------------------
module bb3_norm (
	input  logic                         clk,
	input  logic                         en,
	input  logic [bb3_pkg::SUM_W-1:0]    sum,
	input  logic [bb3_pkg::N_W-1:0]      n,
	input  logic [bb3_pkg::RCP_W-1:0]    m,
	output logic [bb3_pkg::CH_W-1:0]     q_s4
);

	logic [bb3_pkg::X_W-1:0]    x;
	logic [bb3_pkg::PROD_W-1:0] prod;

	assign x    = bb3_pkg::X_W'({sum, 1'b0}) + bb3_pkg::X_W'(n);
	assign prod = bb3_pkg::PROD_W'(x) * bb3_pkg::PROD_W'(m);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4 <= prod[bb3_pkg::RCP_SHIFT +: bb3_pkg::CH_W];
		end
	end

endmodule

// ===== sv/box_blur_3x3_clipped.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_clipped: 3x3 box blur over an RGB raster stream
// Rounded mean of each pixel's in-frame neighbours (9, 6 or 4; fewer in
// frames one pixel wide or high), with a line store and a column-cell window.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Word                                   Notes
// s_*       in   tdata: red, green, blue; tuser: kind   kind 1 = flush word
// m_*       out  tdata: red, green, blue; tlast         tlast on frame's last
// cfg_*     in   index 0 frame_width, 1 frame_height    write only, when idle
//
// One word per clock sustained while m_tready holds. A word taken at the
// input reaches the output register through four register stages (line
// store read, window, sum, multiply).
// Results lag the stream by frame_width+1 words; frame_width+1 flush words
// after the last pixel drain the frame. A flush that arrives early is taken
// and dropped. Stalls on m_tready back up stage by stage; bubbles collapse.
// Reset clears counters, valids and the window; the line store is not
// cleared (entries never written only reach excluded neighbours).
// ----------------------------------------------------------------------------
module box_blur_3x3_clipped #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bb3_pkg::PIX_W-1:0]        s_tdata,  // in_red, in_green, in_blue
	input  logic                             s_tuser,  // operation
	// master side
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bb3_pkg::PIX_W-1:0]        m_tdata,  // out_red, out_green, out_blue
	output logic                             m_tlast,  // frame_end
	// configuration
	input  logic                             cfg_we,
	input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bb3_pkg::CFG_W-1:0]        cfg_data
);

	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column
	localparam int WW    = $clog2(MAX_WIDTH + 1);                    // width reg
	localparam int HW    = $clog2(MAX_HEIGHT + 1);                   // height reg
	localparam int RW    = $clog2(MAX_HEIGHT + 3);                   // row, drain runs past h
	localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

	// ---------------------------------------------------------------- config
	// sizes are stored already clamped to 1..MAX
	logic [WW-1:0] w_q, w_new;
	logic [HW-1:0] h_q, h_new;

	always_comb begin
		if (cfg_data[bb3_pkg::FW_W-1:0] == '0) begin
			w_new = WW'(1);
		end else if (32'(cfg_data[bb3_pkg::FW_W-1:0]) > MAX_WIDTH) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(cfg_data[bb3_pkg::FW_W-1:0]);
		end
		if (cfg_data[bb3_pkg::FH_W-1:0] == '0) begin
			h_new = HW'(1);
		end else if (32'(cfg_data[bb3_pkg::FH_W-1:0]) > MAX_HEIGHT) begin
			h_new = HW'(MAX_HEIGHT);
		end else begin
			h_new = HW'(cfg_data[bb3_pkg::FH_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			h_q <= HW'(H_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bb3_pkg::REG_FRAME_WIDTH:  w_q <= w_new;
				bb3_pkg::REG_FRAME_HEIGHT: h_q <= h_new;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------- flow control
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic adv1, adv2, adv3;

	assign rdy4 = !valid_s4 || m_tready;
	assign adv3 = valid_s3 && rdy4;
	assign rdy3 = !valid_s3 || rdy4;
	assign adv2 = valid_s2 && rdy3;
	assign rdy2 = !valid_s2 || rdy3;
	assign adv1 = valid_s1 && rdy2;   // window shifts only when s2 is free
	assign rdy1 = !valid_s1 || rdy2;

	assign s_tready = rdy1;

	// ------------------------------------------------- stage 0: positions
	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;

	logic              accept, draining, act, emit, enter1;
	logic [CW:0]       ic_inc, oc_inc;
	logic              in_wrap, out_wrap;
	logic [RW:0]       or_inc;
	bb3_pkg::win_mask_t msk0;
	logic              last0;
	bb3_pkg::pix_t     pix0;

	assign accept   = s_tvalid && s_tready;
	assign draining = in_row_q >= RW'(h_q);
	// early flush is taken and dropped
	assign act      = !((s_tuser == bb3_pkg::OP_FLUSH) && !draining);
	assign enter1   = accept && act;
	assign emit     = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));

	assign ic_inc   = (CW+1)'(in_col_q) + (CW+1)'(1);
	assign in_wrap  = ic_inc >= (CW+1)'(w_q);
	assign oc_inc   = (CW+1)'(out_col_q) + (CW+1)'(1);
	assign out_wrap = oc_inc >= (CW+1)'(w_q);
	assign or_inc   = (RW+1)'(out_row_q) + (RW+1)'(1);

	assign msk0.top_ok   = out_row_q != '0;
	assign msk0.bot_ok   = or_inc < (RW+1)'(h_q);
	assign msk0.left_ok  = out_col_q != '0;
	assign msk0.right_ok = !out_wrap;
	assign last0         = !msk0.bot_ok && !msk0.right_ok;

	// while draining the pixel value is dropped
	assign pix0 = draining ? '0 : bb3_pkg::pix_t'(s_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (enter1) begin
			if (emit && last0) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= in_wrap ? '0 : ic_inc[CW-1:0];
				if (in_wrap) begin
					in_row_q <= in_row_q + RW'(1);
				end
				if (emit) begin
					out_col_q <= out_wrap ? '0 : oc_inc[CW-1:0];
					if (out_wrap) begin
						out_row_q <= or_inc[RW-1:0];
					end
				end
			end
		end
	end

	// ------------------------------------------------- stage 1: line store
	bb3_pkg::pix_t      pix_s1;
	logic [CW-1:0]      col_s1;
	logic               emit_s1, last_s1;
	bb3_pkg::win_mask_t msk_s1;
	logic               fwd_s1;
	bb3_pkg::lb_word_t  fwd_word_s1;
	bb3_pkg::lb_word_t  lb_rd, lb_eff, lb_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (enter1) begin
			valid_s1 <= 1'b1;
			// word being written this edge is the one just read: forward it
			fwd_s1   <= valid_s1 && adv1 && (col_s1 == in_col_q);
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (enter1) begin
			pix_s1      <= pix0;
			col_s1      <= in_col_q;
			emit_s1     <= emit;
			msk_s1      <= msk0;
			last_s1     <= last0;
			fwd_word_s1 <= lb_wr;
		end
	end

	assign lb_eff      = fwd_s1 ? fwd_word_s1 : lb_rd;
	assign lb_wr.older = lb_eff.prev;
	assign lb_wr.prev  = pix_s1;

	bb3_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (enter1),
		.rd_addr (in_col_q),
		.rd_data (lb_rd),
		.wr_en   (adv1),
		.wr_addr (col_s1),
		.wr_data (lb_wr)
	);

	// ---------------------------------------------------- stage 2: window
	// three column cells; cell 2 takes the new column, each hands left
	bb3_pkg::col_t      new_col;
	bb3_pkg::col_t      win_col [3];
	bb3_pkg::csum_t     csum    [3];
	bb3_pkg::win_mask_t msk_s2;
	bb3_pkg::row_mask_t rows_s2;
	logic               last_s2;

	assign new_col.top = lb_eff.older;
	assign new_col.mid = lb_eff.prev;
	assign new_col.bot = pix_s1;

	assign rows_s2.top_ok = msk_s2.top_ok;
	assign rows_s2.bot_ok = msk_s2.bot_ok;

	for (genvar k = 0; k < 3; k++) begin : g_cell
		bb3_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (adv1),
			.col_in ((k == 2) ? new_col : win_col[(k + 1) % 3]),
			.rows   (rows_s2),
			.col_q  (win_col[k]),
			.csum   (csum[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv1) begin
			valid_s2 <= emit_s1;
		end else if (adv2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			msk_s2  <= msk_s1;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------ stage 3: sums
	bb3_pkg::sum_t              sum2, sum_s3;
	logic [bb3_pkg::N_W-1:0]    n2, n_s3;
	logic [bb3_pkg::RCP_W-1:0]  m_s3;
	logic                       last_s3;

	always_comb begin
		sum2.red   = bb3_pkg::SUM_W'(msk_s2.left_ok ? csum[0].red : '0)
		           + bb3_pkg::SUM_W'(csum[1].red)
		           + bb3_pkg::SUM_W'(msk_s2.right_ok ? csum[2].red : '0);
		sum2.green = bb3_pkg::SUM_W'(msk_s2.left_ok ? csum[0].green : '0)
		           + bb3_pkg::SUM_W'(csum[1].green)
		           + bb3_pkg::SUM_W'(msk_s2.right_ok ? csum[2].green : '0);
		sum2.blue  = bb3_pkg::SUM_W'(msk_s2.left_ok ? csum[0].blue : '0)
		           + bb3_pkg::SUM_W'(csum[1].blue)
		           + bb3_pkg::SUM_W'(msk_s2.right_ok ? csum[2].blue : '0);
	end

	assign n2 = bb3_pkg::nbr_count(msk_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv2) begin
			valid_s3 <= 1'b1;
		end else if (adv3) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			sum_s3  <= sum2;
			n_s3    <= n2;
			m_s3    <= bb3_pkg::recip(n2);
			last_s3 <= last_s2;
		end
	end

	// ------------------------------------------- stage 4: divide, output reg
	logic [bb3_pkg::CH_W-1:0] red_s4, green_s4, blue_s4;
	logic                     last_s4;

	bb3_norm u_norm_red (
		.clk (clk), .en (adv3), .sum (sum_s3.red), .n (n_s3), .m (m_s3), .q_s4 (red_s4)
	);
	bb3_norm u_norm_green (
		.clk (clk), .en (adv3), .sum (sum_s3.green), .n (n_s3), .m (m_s3), .q_s4 (green_s4)
	);
	bb3_norm u_norm_blue (
		.clk (clk), .en (adv3), .sum (sum_s3.blue), .n (n_s3), .m (m_s3), .q_s4 (blue_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv3) begin
			valid_s4 <= 1'b1;
		end else if (m_tready) begin
			valid_s4 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			last_s4 <= last_s3;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {blue_s4, green_s4, red_s4};
	assign m_tlast  = last_s4;

endmodule

// ===== sv/bb3_checker.sv =====
// ----------------------------------------------------------------------------
// bb3_checker: port-level checks for the box blur
// Output hold under stall, input readiness, and quiet output after reset.
// ----------------------------------------------------------------------------
module bb3_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bb3_pkg::PIX_W-1:0]     m_tdata,
	input logic                          m_tlast
);

	// a stalled word stays, unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed or dropped under stall");

	// a free or draining output register must let the pipeline take a word
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input not ready while output side is free");

	// nothing comes out straight after reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

endmodule

bind box_blur_3x3_clipped bb3_checker u_bb3_checker (.*);
